FILE: src/ebvm_pkg.sv
// Shared types, opcodes and constants of the 8-bit VM execute unit.
package ebvm_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;

   localparam logic [11:0] PC_START = 12'h200;
   localparam logic [15:0] INS_CLS  = 16'h00E0;
   localparam logic [15:0] INS_RET  = 16'h00EE;
   localparam logic [3:0]  FLAG_REG = 4'hF;

   // major opcodes
   localparam logic [3:0] OP_SYS   = 4'h0;
   localparam logic [3:0] OP_JUMP  = 4'h1;
   localparam logic [3:0] OP_CALL  = 4'h2;
   localparam logic [3:0] OP_SEQ   = 4'h3;
   localparam logic [3:0] OP_SNE   = 4'h4;
   localparam logic [3:0] OP_SREQ  = 4'h5;
   localparam logic [3:0] OP_LOAD  = 4'h6;
   localparam logic [3:0] OP_ADDI  = 4'h7;
   localparam logic [3:0] OP_ALU   = 4'h8;

   // ALU group sub-ops
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // response status codes
   localparam logic [1:0] ST_DONE        = 2'd0;
   localparam logic [1:0] ST_IGNORED     = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ST_STACK_ERR   = 2'd3;

   // what one executed instruction does to the state and reports
   typedef struct packed {
      logic [11:0] next_pc;
      logic        clear_screen;
      logic [1:0]  status;
      logic        reg_we;      // write general register x (x below 15)
      logic [7:0]  reg_data;
      logic        flag_we;     // write register 15
      logic [7:0]  flag_data;
      logic [7:0]  dest_value;
      logic [7:0]  flag_value;
      logic        push;
      logic        pop;
   } exec_type;

endpackage

FILE: src/ebvm_regfile.sv
// General register store V0..V14 with reset-valid bits and registered reads.
module ebvm_regfile (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [3:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  logic [3:0] rd_addr_x,
   input  logic [3:0] rd_addr_y,
   output logic [7:0] rd_data_x,
   output logic [7:0] rd_data_y
);

   logic [7:0]  mem [16];
   logic [15:0] valid_ff;
   logic [15:0] valid_in;
   logic [7:0]  data_x_ff;
   logic [7:0]  data_y_ff;
   logic        vx_ff;
   logic        vy_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // a read at the same edge as a write sees the new value
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_x_ff <= (wr_en && wr_addr == rd_addr_x) ? wr_data : mem[rd_addr_x];
         data_y_ff <= (wr_en && wr_addr == rd_addr_y) ? wr_data : mem[rd_addr_y];
         vx_ff     <= valid_in[rd_addr_x];
         vy_ff     <= valid_in[rd_addr_y];
      end
   end

   assign rd_data_x = vx_ff ? data_x_ff : 8'h00;
   assign rd_data_y = vy_ff ? data_y_ff : 8'h00;

endmodule

FILE: src/ebvm_stack.sv
// Return address stack memory with one write and one registered read port.
module ebvm_stack #(
   parameter int DEPTH = ebvm_pkg::STACK_DEPTH_DEFAULT,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [11:0]      wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [11:0]      rd_data
);

   logic [11:0] mem [DEPTH];
   logic [11:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ebvm_exec.sv
// Instruction decode, ALU and next-pc logic for one instruction.
module ebvm_exec #(
   parameter int STACK_DEPTH = ebvm_pkg::STACK_DEPTH_DEFAULT,
   localparam int SP_W = $clog2(STACK_DEPTH + 1)
) (
   input  logic [15:0]        instruction,
   input  logic [11:0]        pc,
   input  logic [SP_W-1:0]    sp,
   input  logic [7:0]         vx,
   input  logic [7:0]         vy,
   input  logic [7:0]         vf,
   input  logic [11:0]        stack_top,
   output ebvm_pkg::exec_type result
);

   logic [3:0] major;
   logic [3:0] x;
   logic [3:0] sub;
   logic [7:0] nn;
   logic [8:0] sum;

   assign major = instruction[15:12];
   assign x     = instruction[11:8];
   assign sub   = instruction[3:0];
   assign nn    = instruction[7:0];
   assign sum   = {1'b0, vx} + {1'b0, vy};

   always_comb begin
      logic       x_we;
      logic [7:0] x_data;
      logic       f_we;
      logic [7:0] f_data;
      logic       vf_we;
      logic [7:0] vf_data;

      result              = '0;
      result.next_pc      = pc;
      result.status       = ebvm_pkg::ST_DONE;
      x_we                = 1'b0;
      x_data              = vx;
      f_we                = 1'b0;
      f_data              = 8'h00;

      unique case (major)
         ebvm_pkg::OP_SYS: begin
            if (instruction == ebvm_pkg::INS_CLS) begin
               result.clear_screen = 1'b1;
               result.next_pc      = pc + 12'd2;
            end else if (instruction == ebvm_pkg::INS_RET) begin
               if (sp == '0) begin
                  result.status = ebvm_pkg::ST_STACK_ERR;
               end else begin
                  result.pop     = 1'b1;
                  result.next_pc = stack_top + 12'd2;
               end
            end else begin
               result.status  = ebvm_pkg::ST_IGNORED;
               result.next_pc = pc + 12'd2;
            end
         end
         ebvm_pkg::OP_JUMP: result.next_pc = instruction[11:0];
         ebvm_pkg::OP_CALL: begin
            if (sp >= SP_W'(STACK_DEPTH)) begin
               result.status = ebvm_pkg::ST_STACK_ERR;
            end else begin
               result.push    = 1'b1;
               result.next_pc = instruction[11:0];
            end
         end
         ebvm_pkg::OP_SEQ:  result.next_pc = pc + ((vx == nn) ? 12'd4 : 12'd2);
         ebvm_pkg::OP_SNE:  result.next_pc = pc + ((vx != nn) ? 12'd4 : 12'd2);
         ebvm_pkg::OP_SREQ: result.next_pc = pc + ((vx == vy) ? 12'd4 : 12'd2);
         ebvm_pkg::OP_LOAD: begin
            x_we           = 1'b1;
            x_data         = nn;
            result.next_pc = pc + 12'd2;
         end
         ebvm_pkg::OP_ADDI: begin
            x_we           = 1'b1;
            x_data         = vx + nn;
            result.next_pc = pc + 12'd2;
         end
         ebvm_pkg::OP_ALU: begin
            result.next_pc = pc + 12'd2;
            x_we           = 1'b1;
            unique case (sub)
               ebvm_pkg::ALU_MOV: x_data = vy;
               ebvm_pkg::ALU_OR:  x_data = vx | vy;
               ebvm_pkg::ALU_AND: x_data = vx & vy;
               ebvm_pkg::ALU_XOR: x_data = vx ^ vy;
               ebvm_pkg::ALU_ADD: begin
                  x_data = sum[7:0];
                  f_we   = 1'b1;
                  f_data = {7'd0, sum[8]};
               end
               ebvm_pkg::ALU_SUB: begin
                  x_data = vx - vy;
                  f_we   = 1'b1;
                  f_data = {7'd0, vx > vy};
               end
               ebvm_pkg::ALU_SHR: begin
                  x_data = {1'b0, vx[7:1]};
                  f_we   = 1'b1;
                  f_data = {7'd0, vx[0]};
               end
               ebvm_pkg::ALU_SUBN: begin
                  x_data = vy - vx;
                  f_we   = 1'b1;
                  f_data = {7'd0, vy > vx};
               end
               ebvm_pkg::ALU_SHL: begin
                  x_data = {vx[6:0], 1'b0};
                  f_we   = 1'b1;
                  f_data = {7'd0, vx[7]};
               end
               default: begin
                  x_we          = 1'b0;
                  result.status = ebvm_pkg::ST_IGNORED;
               end
            endcase
         end
         default: result.status = ebvm_pkg::ST_UNSUPPORTED;
      endcase

      // register 15 lives apart from the store; the flag lands after the result
      vf_we   = f_we || (x_we && x == ebvm_pkg::FLAG_REG);
      vf_data = f_we ? f_data : x_data;

      result.reg_we     = x_we && (x != ebvm_pkg::FLAG_REG);
      result.reg_data   = x_data;
      result.flag_we    = vf_we;
      result.flag_data  = vf_data;
      result.flag_value = vf_we ? vf_data : vf;
      result.dest_value = (x == ebvm_pkg::FLAG_REG) ? result.flag_value
                        : (x_we ? x_data : vx);
   end

endmodule

FILE: src/eight_bit_vm_execute_unit.sv
// Top level of the 8-bit VM execute unit: request register, execute, response register.
//
//   channel   | ports                                   | direction
//   ----------+-----------------------------------------+----------
//   request   | req_valid, req_stall, req_instruction   | in
//   response  | rsp_valid, rsp_stall, rsp_next_pc,      | out
//             | rsp_clear_screen, rsp_status,           |
//             | rsp_dest_value, rsp_flag_value          |
//
// One instruction per cycle sustained while the response is not stalled. An accepted
// request loads the request register and reads Vx, Vy and the stack top; once the
// response slot is free it executes, updates state and loads the response register.
// Reset clears all registers to zero, the pc to 0x200 and the stack pointer.
// The return stack is not cleared. A stalled response holds the instruction
// in the request register; the request side then stalls too.
module eight_bit_vm_execute_unit #(
   parameter int STACK_DEPTH = ebvm_pkg::STACK_DEPTH_DEFAULT,
   localparam int SP_W  = $clog2(STACK_DEPTH + 1),
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_instruction,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_next_pc,
   output logic        rsp_clear_screen,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_dest_value,
   output logic [7:0]  rsp_flag_value
);

   // request register
   logic        ins_valid_ff, ins_valid_in;
   logic [15:0] ins_ff;

   // architectural state
   logic [11:0]     pc_ff, pc_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [7:0]      vf_ff, vf_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   ebvm_pkg::exec_type  rsp_ff;

   logic               rsp_free;
   logic               execute;
   logic               accept;
   logic [7:0]         rf_x, rf_y;
   logic [7:0]         vx, vy;
   logic [11:0]        stack_top;
   logic [IDX_W-1:0]   stack_rd_addr;
   ebvm_pkg::exec_type ex;

   // the response slot is free when empty or being taken this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign execute   = ins_valid_ff && rsp_free;
   assign req_stall = ins_valid_ff && !rsp_free;
   assign accept    = req_valid && !req_stall;

   // register 15 is a flop of its own; the store serves V0..V14
   assign vx = (ins_ff[11:8] == ebvm_pkg::FLAG_REG) ? vf_ff : rf_x;
   assign vy = (ins_ff[7:4]  == ebvm_pkg::FLAG_REG) ? vf_ff : rf_y;

   ebvm_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (execute && ex.reg_we),
      .wr_addr   (ins_ff[11:8]),
      .wr_data   (ex.reg_data),
      .rd_en     (accept),
      .rd_addr_x (req_instruction[11:8]),
      .rd_addr_y (req_instruction[7:4]),
      .rd_data_x (rf_x),
      .rd_data_y (rf_y)
   );

   // stack top is read for the pointer value that holds once this edge is done
   assign stack_rd_addr = IDX_W'(sp_in - 1'b1);

   ebvm_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (execute && ex.push),
      .wr_addr (sp_ff[IDX_W-1:0]),
      .wr_data (pc_ff),
      .rd_en   (accept),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_top)
   );

   ebvm_exec #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .instruction (ins_ff),
      .pc          (pc_ff),
      .sp          (sp_ff),
      .vx          (vx),
      .vy          (vy),
      .vf          (vf_ff),
      .stack_top   (stack_top),
      .result      (ex)
   );

   always_comb begin
      pc_in = pc_ff;
      sp_in = sp_ff;
      vf_in = vf_ff;
      if (execute) begin
         pc_in = ex.next_pc;
         if (ex.push) begin
            sp_in = sp_ff + 1'b1;
         end else if (ex.pop) begin
            sp_in = sp_ff - 1'b1;
         end
         if (ex.flag_we) begin
            vf_in = ex.flag_data;
         end
      end
   end

   always_comb begin
      ins_valid_in = ins_valid_ff;
      if (accept) begin
         ins_valid_in = 1'b1;
      end else if (execute) begin
         ins_valid_in = 1'b0;
      end
      rsp_valid_in = execute || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= ebvm_pkg::PC_START;
         sp_ff        <= '0;
         vf_ff        <= 8'h00;
      end else begin
         ins_valid_ff <= ins_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         vf_ff        <= vf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ins_ff <= req_instruction;
      end
      if (execute) begin
         rsp_ff <= ex;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_ff.next_pc;
   assign rsp_clear_screen = rsp_ff.clear_screen;
   assign rsp_status       = rsp_ff.status;
   assign rsp_dest_value   = rsp_ff.dest_value;
   assign rsp_flag_value   = rsp_ff.flag_value;

endmodule

FILE: src/ebvm_checker.sv
// Port-level checks of the 8-bit VM execute unit and their bind.
module ebvm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_next_pc,
   input logic        rsp_clear_screen,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_dest_value,
   input logic [7:0]  rsp_flag_value
);

   // a stalled response keeps its whole payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_pc)
         && $stable(rsp_status) && $stable(rsp_dest_value)
         && $stable(rsp_flag_value) && $stable(rsp_clear_screen))
      else $error("stalled response changed");

   // a clear-screen response always completes normally
   a_cls_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clear_screen |-> rsp_status == ebvm_pkg::ST_DONE)
      else $error("clear screen with non-done status");

   // reset empties both the response slot and the request register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // the request side only stalls while a response is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

endmodule

bind eight_bit_vm_execute_unit ebvm_checker u_ebvm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_next_pc      (rsp_next_pc),
   .rsp_clear_screen (rsp_clear_screen),
   .rsp_status       (rsp_status),
   .rsp_dest_value   (rsp_dest_value),
   .rsp_flag_value   (rsp_flag_value)
);
